// File: rtl/median_window_outlier_gate_unit_defines.svh
// assertion macros for the median window outlier gate checker
// no dependencies; each macro expects i_clk and i_rst_n in scope
`ifndef MEDIAN_WINDOW_OUTLIER_GATE_UNIT_DEFINES_SVH
`define MEDIAN_WINDOW_OUTLIER_GATE_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MWOG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mwog check failed");

// next-cycle implication, disabled in reset
`define MWOG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mwog check failed");

`endif

// File: rtl/mwog_pkg.sv
// shared types and constants for the median window outlier gate
// no dependencies
`timescale 1ns / 1ps

package mwog_pkg;

    localparam int WINDOW  = 16;
    localparam int TAG_W   = $clog2(WINDOW);
    localparam int MED_POS = WINDOW / 2;
    localparam int SMP_W   = 16;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_TEST   = 2'd1;
    localparam logic [1:0] OP_REFILL = 2'd2;

    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_FILL      = 1'b1;

    localparam logic [15:0]       THR_RESET  = 16'd500;
    localparam logic [SMP_W-1:0]  FILL_RESET = '0;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [SMP_W-1:0] sample;
    } t_in_word;

    typedef struct packed {
        logic                    is_outlier;
        logic signed [SMP_W-1:0] window_median;
        logic                    window_filled;
    } t_out_word;

    // one window entry: value and its age slot in the time-ordered window
    typedef struct packed {
        logic signed [SMP_W-1:0] val;
        logic [TAG_W-1:0]        tag;
    } t_slot;

    typedef struct packed {
        logic                    update;
        logic                    refill;
        logic                    shift_tags;
        logic [TAG_W-1:0]        kill_tag;
        logic [TAG_W-1:0]        drop_pos;
        logic signed [SMP_W-1:0] new_val;
        logic [TAG_W-1:0]        new_tag;
        logic signed [SMP_W-1:0] fill_val;
    } t_cell_ctl;

endpackage

// File: rtl/mwog_cell.sv
// one cell of the sorted window chain: holds one value and its age tag
// depends on mwog_pkg
`timescale 1ns / 1ps

module mwog_cell import mwog_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [TAG_W-1:0] i_idx,
    input  t_slot            i_right,
    input  logic             i_right_vacant,
    input  t_slot            i_left_eff,
    input  logic             i_left_gt,
    output t_slot            o_slot,
    output t_slot            o_eff,
    output logic             o_gt,
    output logic             o_match
);

    t_slot r_slot;
    t_slot n_slot;
    logic  w_after_drop;
    logic  w_eff_vacant;
    logic [TAG_W-1:0] w_dec;

    assign w_dec        = TAG_W'(i_ctl.shift_tags);
    assign w_after_drop = (i_idx >= i_ctl.drop_pos);
    assign o_eff        = w_after_drop ? i_right : r_slot;
    assign w_eff_vacant = w_after_drop & i_right_vacant;
    assign o_gt         = w_eff_vacant | ($signed(o_eff.val) > $signed(i_ctl.new_val));
    assign o_match      = (r_slot.tag == i_ctl.kill_tag);
    assign o_slot       = r_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.refill) begin
            n_slot.val = i_ctl.fill_val;
            n_slot.tag = i_idx;
        end else if (i_ctl.update) begin
            if (!o_gt) begin
                n_slot.val = o_eff.val;
                n_slot.tag = o_eff.tag - w_dec;
            end else if (i_left_gt) begin
                n_slot.val = i_left_eff.val;
                n_slot.tag = i_left_eff.tag - w_dec;
            end else begin
                n_slot.val = i_ctl.new_val;
                n_slot.tag = i_ctl.new_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.val <= FILL_RESET;
            r_slot.tag <= i_idx;
        end else begin
            r_slot <= n_slot;
        end
    end

endmodule

// File: rtl/mwog_locate.sv
// finds the sorted position of the entry whose age tag is being retired
// depends on mwog_pkg
`timescale 1ns / 1ps

module mwog_locate import mwog_pkg::*; (
    input  logic [WINDOW-1:0] i_match,
    output logic [TAG_W-1:0]  o_pos
);

    always_comb begin
        o_pos = '0;
        for (int j = 0; j < WINDOW; j++) begin
            o_pos = o_pos | (i_match[j] ? TAG_W'(j) : '0);
        end
    end

endmodule

// File: rtl/median_window_outlier_gate_unit.sv
// top level of the median window outlier gate: control, config and cell chain
// depends on mwog_pkg, mwog_cell, mwog_locate
//
// channel   direction  handshake                  word
// in        input      i_in_valid / o_in_stall    t_in_word  (op, sample)
// out       output     o_out_valid / i_out_stall  t_out_word (is_outlier, median, filled)
// cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// each word passes through the steps accept, locate the retiring entry, update the chain, load output
// the sorted chain keeps the median in a fixed cell, so the median is read in the accept cycle
// reset is synchronous and active low; input stalls in reset, the chain holds the reset fill
// a stalled output holds the block in its last step until the output register frees
`timescale 1ns / 1ps

module median_window_outlier_gate_unit import mwog_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in_word   i_in_word,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_out_word  o_out_word,
    input  logic       i_out_stall,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOCATE = 4'b0010,
        S_UPDATE = 4'b0100,
        S_PUSH   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [15:0]             r_thr;
    logic signed [SMP_W-1:0] r_fill;
    logic [TAG_W-1:0]        r_fill_pos;
    logic                    r_full;
    logic [1:0]              r_op;
    logic signed [SMP_W-1:0] r_sample;
    logic [TAG_W-1:0]        r_drop;
    logic                    r_res_outl;
    logic signed [SMP_W-1:0] r_res_med;
    logic                    r_out_valid;
    t_out_word               r_out_word;

    t_cell_ctl         w_ctl;
    t_slot             w_slot [WINDOW];
    t_slot             w_eff  [WINDOW];
    logic [WINDOW-1:0] w_gt;
    logic [WINDOW-1:0] w_match;
    logic [TAG_W-1:0]  w_pos;
    logic              w_accept;
    logic              w_out_free;
    logic signed [SMP_W:0] w_diff;
    logic [SMP_W:0]    w_abs;
    logic              w_outl;

    assign w_accept   = i_in_valid & (r_state == S_IDLE);
    assign w_out_free = !r_out_valid | !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) | !i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // distance to current median
    assign w_diff = {i_in_word.sample[SMP_W-1], i_in_word.sample}
                  - {w_slot[MED_POS].val[SMP_W-1], w_slot[MED_POS].val};
    assign w_abs  = w_diff[SMP_W] ? (SMP_W+1)'(-w_diff) : w_diff;
    assign w_outl = (i_in_word.op == OP_TEST) && (w_abs > {1'b0, r_thr});

    always_comb begin
        w_ctl.update     = (r_state == S_UPDATE) && (r_op == OP_INSERT);
        w_ctl.refill     = (r_state == S_UPDATE) && (r_op == OP_REFILL);
        w_ctl.shift_tags = r_full;
        w_ctl.kill_tag   = r_full ? '0 : r_fill_pos;
        w_ctl.drop_pos   = r_drop;
        w_ctl.new_val    = r_sample;
        w_ctl.new_tag    = r_full ? TAG_W'(WINDOW - 1) : r_fill_pos;
        w_ctl.fill_val   = r_fill;
    end

    for (genvar j = 0; j < WINDOW; j++) begin : g_cell
        t_slot w_right;
        logic  w_right_vacant;
        t_slot w_left_eff;
        logic  w_left_gt;

        if (j == WINDOW - 1) begin : g_last
            assign w_right        = '0;
            assign w_right_vacant = 1'b1;
        end else begin : g_mid
            assign w_right        = w_slot[j+1];
            assign w_right_vacant = 1'b0;
        end

        if (j == 0) begin : g_first
            assign w_left_eff = '0;
            assign w_left_gt  = 1'b0;
        end else begin : g_rest
            assign w_left_eff = w_eff[j-1];
            assign w_left_gt  = w_gt[j-1];
        end

        mwog_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (w_ctl),
            .i_idx          (TAG_W'(j)),
            .i_right        (w_right),
            .i_right_vacant (w_right_vacant),
            .i_left_eff     (w_left_eff),
            .i_left_gt      (w_left_gt),
            .o_slot         (w_slot[j]),
            .o_eff          (w_eff[j]),
            .o_gt           (w_gt[j]),
            .o_match        (w_match[j])
        );
    end

    mwog_locate u_locate (
        .i_match (w_match),
        .o_pos   (w_pos)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_accept) n_state = S_LOCATE;
            S_LOCATE: n_state = S_UPDATE;
            S_UPDATE: n_state = S_PUSH;
            S_PUSH:   if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= THR_RESET;
            r_fill      <= FILL_RESET;
            r_fill_pos  <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_THRESHOLD: r_thr  <= i_cfg_data;
                    CFG_FILL:      r_fill <= i_cfg_data;
                    default:       r_thr  <= r_thr;
                endcase
            end

            if (r_state == S_UPDATE) begin
                if (r_op == OP_INSERT) begin
                    if (r_full) begin
                        r_fill_pos <= TAG_W'(WINDOW - 1);
                    end else if (r_fill_pos == TAG_W'(WINDOW - 1)) begin
                        r_full <= 1'b1;
                    end else begin
                        r_fill_pos <= r_fill_pos + TAG_W'(1);
                    end
                end else if (r_op == OP_REFILL) begin
                    r_fill_pos <= '0;
                    r_full     <= 1'b0;
                end
            end

            if ((r_state == S_PUSH) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= i_in_word.op;
            r_sample   <= i_in_word.sample;
            r_res_outl <= w_outl;
            r_res_med  <= w_slot[MED_POS].val;
        end
        if (r_state == S_LOCATE) begin
            r_drop <= w_pos;
        end
        if ((r_state == S_PUSH) && w_out_free) begin
            r_out_word.is_outlier    <= r_res_outl;
            r_out_word.window_median <= r_res_med;
            r_out_word.window_filled <= r_full;
        end
    end

endmodule

// File: rtl/mwog_checker.sv
// port-level checks for the median window outlier gate, bound to the top level
// depends on mwog_pkg and median_window_outlier_gate_unit_defines.svh
`timescale 1ns / 1ps
`include "median_window_outlier_gate_unit_defines.svh"

module mwog_checker import mwog_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input t_out_word   o_out_word,
    input logic        i_out_stall
);

    // held output word
    `MWOG_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word))

    // an accepted word keeps the block busy for its work cycles
    `MWOG_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall ##1 o_in_stall)

    // a new output word only comes out of a busy block
    `MWOG_ASSERT_NOW(a_out_from_work, $rose(o_out_valid), $past(o_in_stall))

endmodule

bind median_window_outlier_gate_unit mwog_checker u_mwog_checker (.*);

// File: sim/tb_median_window_outlier_gate_unit.sv
// testbench for median_window_outlier_gate_unit: directed words, then random words under
// three stall mixes and several register settings, checked against a window predictor
// depends on mwog_pkg and the rtl of median_window_outlier_gate_unit
`timescale 1ns / 1ps

module tb_median_window_outlier_gate_unit import mwog_pkg::*; ();

    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word want;
    } t_directed_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    t_in_word    i_in_word = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_word   o_out_word;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_THRESHOLD;
    logic [15:0] i_cfg_data = '0;

    // predictor state
    logic signed [SMP_W-1:0] window_vals [WINDOW] = '{default: FILL_RESET};
    int                      fill_pos = 0;
    bit                      win_full = 1'b0;
    logic [15:0]             gate_thr = THR_RESET;
    logic signed [SMP_W-1:0] gate_fill = FILL_RESET;

    t_out_word     pending_gate_words [$];
    t_directed_row directed_rows [$];
    int            mismatch_count = 0;
    int            idle_in_pct = 7;
    int            idle_out_pct = 85;
    int            hold_requests = 0;
    int            hold_served = 0;
    int            hold_left = 0;

    median_window_outlier_gate_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic signed [SMP_W-1:0] window_median();
        logic signed [SMP_W-1:0] sorted [WINDOW];
        logic signed [SMP_W-1:0] v;
        int j;
        for (int i = 0; i < WINDOW; i++) begin
            v = window_vals[i];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        return sorted[MED_POS];
    endfunction

    // applies one word to the predicted window and returns the word it should produce
    function automatic t_out_word gate_step(t_in_word w);
        t_out_word r;
        int d;
        r.window_median = window_median();
        r.is_outlier = 1'b0;
        case (w.op)
            OP_INSERT: begin
                if (win_full) begin
                    for (int i = 0; i < WINDOW - 1; i++) window_vals[i] = window_vals[i+1];
                    window_vals[WINDOW-1] = w.sample;
                    fill_pos = WINDOW - 1;
                end else begin
                    window_vals[fill_pos] = w.sample;
                    if (fill_pos == WINDOW - 1) win_full = 1'b1;
                    else fill_pos++;
                end
            end
            OP_TEST: begin
                d = int'($signed(w.sample)) - int'($signed(r.window_median));
                if (d < 0) d = -d;
                r.is_outlier = (d > int'(gate_thr));
            end
            OP_REFILL: begin
                for (int i = 0; i < WINDOW; i++) window_vals[i] = gate_fill;
                fill_pos = 0;
                win_full = 1'b0;
            end
            default: ;
        endcase
        r.window_filled = win_full;
        return r;
    endfunction

    function automatic t_directed_row dir_row(logic [1:0] op, int s, bit typed,
                                              logic outl, int med, logic filled);
        t_directed_row r;
        r.w.op = op;
        r.w.sample = s[15:0];
        r.typed = typed;
        r.want.is_outlier = outl;
        r.want.window_median = med[15:0];
        r.want.window_filled = filled;
        return r;
    endfunction

    function automatic void add_row(t_directed_row r);
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    task automatic send_word(t_in_word w, bit typed, t_out_word want);
        t_out_word pred;
        while ($urandom_range(99) < idle_in_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pred = gate_step(w);
        pending_gate_words.insert(pending_gate_words.size(), typed ? want : pred);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_gate_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_gate_config(logic [15:0] thr, logic [15:0] fill);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_THRESHOLD;
        i_cfg_data <= thr;
        @(posedge i_clk);
        gate_thr = thr;
        i_cfg_index <= CFG_FILL;
        i_cfg_data <= fill;
        @(posedge i_clk);
        gate_fill = fill;
        i_cfg_we <= 1'b0;
    endtask

    // output side: check accepted words, then pick the next stall
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                if (pending_gate_words.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected word: outlier=%0d median=%0d filled=%0d",
                                 o_out_word.is_outlier, $signed(o_out_word.window_median),
                                 o_out_word.window_filled);
                end else begin
                    want = pending_gate_words.pop_front();
                    if (o_out_word.is_outlier !== want.is_outlier ||
                        o_out_word.window_median !== want.window_median ||
                        o_out_word.window_filled !== want.window_filled) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %0d/%0d/%0d, actual %0d/%0d/%0d",
                                     want.is_outlier, $signed(want.window_median),
                                     want.window_filled, o_out_word.is_outlier,
                                     $signed(o_out_word.window_median),
                                     o_out_word.window_filled);
                    end
                end
            end
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < idle_out_pct);
            end
        end
    end

    initial begin
        t_in_word  w;
        t_out_word none;
        logic [15:0] thr_set [6];
        logic [15:0] fill_set [6];
        int med_i;
        int s_i;
        int base;

        none = '0;
        thr_set  = '{16'd0, 16'd65535, 16'd500, 16'($urandom_range(3000)), 16'd1,
                     16'($urandom_range(3000))};
        fill_set = '{16'h8000, 16'h7fff, 16'h0000, 16'($urandom), 16'($urandom),
                     16'($urandom)};

        // after reset the window holds zeros, so early medians are zero
        add_row(dir_row(OP_TEST, 500, 1, 1'b0, 0, 1'b0));
        add_row(dir_row(OP_TEST, 501, 1, 1'b1, 0, 1'b0));
        add_row(dir_row(OP_TEST, -501, 1, 1'b1, 0, 1'b0));
        add_row(dir_row(OP_TEST, -32768, 1, 1'b1, 0, 1'b0));
        add_row(dir_row(2'd3, -1, 1, 1'b0, 0, 1'b0));
        add_row(dir_row(OP_INSERT, 32767, 1, 1'b0, 0, 1'b0));
        add_row(dir_row(OP_REFILL, 0, 1, 1'b0, 0, 1'b0));
        for (int k = 0; k < WINDOW; k++)
            add_row(dir_row(OP_INSERT, (k == 0) ? -32768 : k * 997 - 7000,
                            0, 1'b0, 0, 1'b0));
        add_row(dir_row(OP_INSERT, 32767, 0, 1'b0, 0, 1'b0));
        add_row(dir_row(OP_TEST, 0, 0, 1'b0, 0, 1'b0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].want);

        for (int p = 0; p < 6; p++) begin
            idle_in_pct  = (p < 2) ? 7 : (p < 4) ? 85 : 0;
            idle_out_pct = (p < 2) ? 85 : (p < 4) ? 7 : 0;
            wait_drained();
            set_gate_config(thr_set[p], fill_set[p]);
            w.op = OP_REFILL;  w.sample = '0;        send_word(w, 0, none);
            w.op = OP_TEST;    w.sample = 16'h7fff;  send_word(w, 0, none);
            w.op = OP_TEST;    w.sample = 16'h8000;  send_word(w, 0, none);
            // long output hold while words keep coming
            if (p == 5) hold_requests++;
            base = $urandom_range(20000) - 10000;
            for (int n = 0; n < 60; n++) begin
                s_i = $urandom_range(99);
                if (s_i < 52) begin
                    w.op = OP_INSERT;
                    if ($urandom_range(9) < 6) s_i = base + $urandom_range(600) - 300;
                    else s_i = $urandom;
                end else if (s_i < 95) begin
                    w.op = OP_TEST;
                    med_i = int'(window_median());
                    case ($urandom_range(3))
                        0: s_i = $urandom;
                        1: s_i = med_i + int'(gate_thr) + int'($urandom_range(2)) - 1;
                        2: s_i = med_i - int'(gate_thr) - int'($urandom_range(2)) + 1;
                        default: s_i = med_i + int'($urandom_range(400)) - 200;
                    endcase
                end else if (s_i < 98) begin
                    w.op = OP_REFILL;
                    s_i = $urandom;
                end else begin
                    w.op = 2'd3;
                    s_i = $urandom;
                end
                w.sample = s_i[15:0];
                send_word(w, 0, none);
            end
        end

        wait_drained();
        if (mismatch_count == 0 && pending_gate_words.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
